/* rtl/i2ew_pkg.sv */
// Package for the integer-to-English-words block: word codes, digit and slot counts.
// No dependencies; used by integer_to_english_words_top.
`timescale 1ns / 1ps

package i2ew_pkg;

  // Word codes on the result channel
  localparam logic [4:0] W_ZERO     = 5'd0;
  localparam logic [4:0] W_TEEN_0   = 5'd10;  // teen code is W_TEEN_0 + units digit
  localparam logic [4:0] W_TENS_0   = 5'd18;  // tens code is W_TENS_0 + tens digit
  localparam logic [4:0] W_HUNDRED  = 5'd28;
  localparam logic [4:0] W_THOUSAND = 5'd29;
  localparam logic [4:0] W_MILLION  = 5'd30;
  localparam logic [4:0] W_BILLION  = 5'd31;

  // Decimal layout: four groups of three digits, billion group first in reading order
  localparam int NUM_DIGITS  = 12;
  localparam int NUM_GROUPS  = 4;
  localparam int GROUP_SLOTS = 5;   // hundreds digit, Hundred, tens/teen, unit, scale
  localparam int NUM_SLOTS   = NUM_GROUPS * GROUP_SLOTS;

  // Slot phases inside one group
  localparam logic [2:0] PH_HUND_DIGIT = 3'd0;
  localparam logic [2:0] PH_HUND_WORD  = 3'd1;
  localparam logic [2:0] PH_TENS       = 3'd2;
  localparam logic [2:0] PH_UNIT       = 3'd3;
  localparam logic [2:0] PH_SCALE      = 3'd4;

  typedef logic [3:0] digit_t;

endpackage

/* rtl/integer_to_english_words_top.sv */
// Top level of the integer-to-English-words block: binary-to-decimal converter and word sequencer.
// Depends on i2ew_pkg.
`timescale 1ns / 1ps

// Reads a non-negative integer out as English word codes, one word per output transaction,
// with last set on the final word. An input transaction starts a shift-and-add-3 binary to
// decimal conversion, one input bit per cycle through a shared digit-correct-and-shift unit.
// A sequencer then walks the word slots (five per group of three digits) at one slot per cycle,
// holding on a slot whose word waits on a stalled output, and sends each word that applies.
// The units group has no scale word, so at most nineteen slots are walked; the walk ends early
// after the last word. in_stall_o is high from acceptance until the last word is loaded into
// the output register, and a new item may enter while that last word still waits to be taken.
module integer_to_english_words_top #(
  parameter int VALUE_BITS = 31
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [30:0] value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [4:0]  word_o,
  output logic        last_o
);

  localparam int CntW = $clog2(VALUE_BITS + 1);
  localparam int BcdW = 4 * i2ew_pkg::NUM_DIGITS;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [VALUE_BITS-1:0] bin_q, bin_d;
  logic [BcdW-1:0]       bcd_q, bcd_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [1:0]            grp_q, grp_d;
  logic [2:0]            ph_q, ph_d;
  logic                  out_valid_q, out_valid_d;
  logic [4:0]            word_q, word_d;
  logic                  last_q, last_d;

  logic                  in_acc;
  logic                  out_free;
  logic [BcdW-1:0]       bcd_adj;
  i2ew_pkg::digit_t      dig [i2ew_pkg::NUM_DIGITS];
  logic [i2ew_pkg::NUM_SLOTS-1:0] slot_emit;
  logic [4:0]            slot_word [i2ew_pkg::NUM_SLOTS];
  logic [4:0]            idx;
  logic [i2ew_pkg::NUM_SLOTS-1:0] above_mask;
  logic                  is_last;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign word_o      = word_q;
  assign last_o      = last_q;

  // Correct each decimal digit that is five or more before the next shift
  always_comb begin
    bcd_adj = bcd_q;
    for (int i = 0; i < i2ew_pkg::NUM_DIGITS; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end
    end
  end

  // Split the decimal result into digits
  always_comb begin
    for (int i = 0; i < i2ew_pkg::NUM_DIGITS; i++) begin
      dig[i] = bcd_q[4*i +: 4];
    end
  end

  // Decide for every word slot whether it speaks and what it says
  always_comb begin
    int k;
    int s;
    i2ew_pkg::digit_t h, t, u;
    logic nz;
    for (int p = 0; p < i2ew_pkg::NUM_GROUPS; p++) begin
      k  = i2ew_pkg::NUM_GROUPS - 1 - p;
      s  = p * i2ew_pkg::GROUP_SLOTS;
      h  = dig[3*k + 2];
      t  = dig[3*k + 1];
      u  = dig[3*k];
      nz = (h != 4'd0) || (t != 4'd0) || (u != 4'd0);
      // hundreds digit and the word Hundred
      slot_emit[s]     = (h != 4'd0);
      slot_word[s]     = {1'b0, h};
      slot_emit[s + 1] = (h != 4'd0);
      slot_word[s + 1] = i2ew_pkg::W_HUNDRED;
      // tens word or teen
      slot_emit[s + 2] = (t != 4'd0);
      if (t == 4'd1) begin
        slot_word[s + 2] = i2ew_pkg::W_TEEN_0 + {1'b0, u};
      end else begin
        slot_word[s + 2] = i2ew_pkg::W_TENS_0 + {1'b0, t};
      end
      // unit word, absent after a teen
      slot_emit[s + 3] = (u != 4'd0) && (t != 4'd1);
      slot_word[s + 3] = {1'b0, u};
      // scale word for the upper groups
      slot_emit[s + 4] = nz && (k != 0);
      slot_word[s + 4] = i2ew_pkg::W_HUNDRED + 5'(k);
    end
  end

  // Locate the current slot and check whether any later slot speaks
  assign idx        = {1'b0, grp_q, 2'b00} + {3'b000, grp_q} + {2'b00, ph_q};
  assign above_mask = ~((20'd2 << idx) - 20'd1);
  assign is_last    = ((slot_emit & above_mask) == '0);

  // Sequence conversion and word emission
  always_comb begin
    state_d     = state_q;
    bin_d       = bin_q;
    bcd_d       = bcd_q;
    cnt_d       = cnt_q;
    grp_d       = grp_q;
    ph_d        = ph_q;
    out_valid_d = out_valid_q && out_stall_i;
    word_d      = word_q;
    last_d      = last_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          bin_d   = value_i[VALUE_BITS-1:0];
          bcd_d   = '0;
          cnt_d   = '0;
          state_d = ST_CONV;
        end
      end
      ST_CONV: begin
        // shift one binary bit into the corrected decimal digits
        {bcd_d, bin_d} = {bcd_adj, bin_q} << 1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CntW'(VALUE_BITS - 1)) begin
          grp_d   = '0;
          ph_d    = i2ew_pkg::PH_HUND_DIGIT;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_emit == '0) begin
          // the whole number is zero
          if (out_free) begin
            out_valid_d = 1'b1;
            word_d      = i2ew_pkg::W_ZERO;
            last_d      = 1'b1;
            state_d     = ST_IDLE;
          end
        end else if (!slot_emit[idx] || out_free) begin
          if (slot_emit[idx]) begin
            out_valid_d = 1'b1;
            word_d      = slot_word[idx];
            last_d      = is_last;
          end
          if (slot_emit[idx] && is_last) begin
            state_d = ST_IDLE;
          end else if (ph_q == i2ew_pkg::PH_SCALE) begin
            ph_d  = i2ew_pkg::PH_HUND_DIGIT;
            grp_d = grp_q + 1'b1;
          end else begin
            ph_d = ph_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold control state under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      grp_q       <= '0;
      ph_q        <= i2ew_pkg::PH_HUND_DIGIT;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      grp_q       <= grp_d;
      ph_q        <= ph_d;
    end
  end

  // Advance the datapath registers
  always_ff @(posedge clk_i) begin
    bin_q  <= bin_d;
    bcd_q  <= bcd_d;
    word_q <= word_d;
    last_q <= last_d;
  end

endmodule

/* tb/tb_integer_to_english_words_top.sv */
// Testbench for integer_to_english_words_top: directed and random numbers, word stream checked.
// Depends on i2ew_pkg and the RTL of the block; self-contained otherwise.
`timescale 1ns / 1ps

module tb_integer_to_english_words_top;

  localparam int          VALUE_BITS   = 31;
  localparam int          NUM_ROWS     = 24;
  localparam int          NUM_RANDOM   = 200;
  localparam int          QUIET_ITEMS  = 40;
  localparam int          DRAIN_CYCLES = 2 * (VALUE_BITS + 21);
  localparam int unsigned BILLION      = 1000000000;
  localparam int unsigned MILLION      = 1000000;
  localparam int unsigned THOUSAND     = 1000;
  localparam longint unsigned MAX_VALUE = (64'd1 << VALUE_BITS) - 1;

  typedef struct packed {
    logic [4:0] word;
    logic       last;
  } spoken_word_t;

  // One directed number; has_word marks a one-word reading typed in by hand
  typedef struct packed {
    logic [30:0] value;
    logic        has_word;
    logic [4:0]  word;
  } number_row_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic [30:0] value_i     = '0;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [4:0]  word_o;
  logic        last_o;

  spoken_word_t pending_words[$];
  logic         quiet_phase = 1'b0;
  int           error_count = 0;
  int           words_checked = 0;
  int           numbers_read = 0;
  int           stall_left = 0;

  number_row_t number_rows [NUM_ROWS] = '{
    '{31'd0,          1'b1, i2ew_pkg::W_ZERO},
    '{31'd13,         1'b1, i2ew_pkg::W_TEEN_0 + 5'd3},
    '{31'd19,         1'b1, i2ew_pkg::W_TEEN_0 + 5'd9},
    '{31'd90,         1'b1, i2ew_pkg::W_TENS_0 + 5'd9},
    '{31'd1,          1'b0, i2ew_pkg::W_ZERO},
    '{31'd20,         1'b0, i2ew_pkg::W_ZERO},
    '{31'd21,         1'b0, i2ew_pkg::W_ZERO},
    '{31'd99,         1'b0, i2ew_pkg::W_ZERO},
    '{31'd100,        1'b0, i2ew_pkg::W_ZERO},
    '{31'd101,        1'b0, i2ew_pkg::W_ZERO},
    '{31'd110,        1'b0, i2ew_pkg::W_ZERO},
    '{31'd999,        1'b0, i2ew_pkg::W_ZERO},
    '{31'd1000,       1'b0, i2ew_pkg::W_ZERO},
    '{31'd1001,       1'b0, i2ew_pkg::W_ZERO},
    '{31'd1000000,    1'b0, i2ew_pkg::W_ZERO},
    '{31'd1000010,    1'b0, i2ew_pkg::W_ZERO},
    '{31'd12000000,   1'b0, i2ew_pkg::W_ZERO},
    '{31'd100010001,  1'b0, i2ew_pkg::W_ZERO},
    '{31'd987654321,  1'b0, i2ew_pkg::W_ZERO},
    '{31'd1000000000, 1'b0, i2ew_pkg::W_ZERO},
    '{31'd1111111111, 1'b0, i2ew_pkg::W_ZERO},
    '{31'd1777777777, 1'b0, i2ew_pkg::W_ZERO},
    '{31'd2000000000, 1'b0, i2ew_pkg::W_ZERO},
    '{31'd2147483647, 1'b0, i2ew_pkg::W_ZERO}
  };

  integer_to_english_words_top #(
    .VALUE_BITS(VALUE_BITS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .word_o     (word_o),
    .last_o     (last_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic void add_word(input logic [4:0] code);
    pending_words.push_back(spoken_word_t'{code, 1'b0});
  endfunction

  // Append the words of one three-digit group, nothing for a zero group
  function automatic void spell_group(input int unsigned group);
    int unsigned hund;
    int unsigned rest;
    hund = group / 100;
    rest = group % 100;
    // digit words One..Nine carry the digit itself as their code
    if (hund != 0) begin
      add_word(5'(hund));
      add_word(i2ew_pkg::W_HUNDRED);
    end
    if (rest >= 20) begin
      add_word(i2ew_pkg::W_TENS_0 + 5'(rest / 10));
      if (rest % 10 != 0) add_word(5'(rest % 10));
    end else if (rest >= 10) begin
      add_word(i2ew_pkg::W_TEEN_0 + 5'(rest - 10));
    end else if (rest != 0) begin
      add_word(5'(rest));
    end
  endfunction

  // Queue the full reading of one number, last flag on its final word
  function automatic void spell_number(input logic [30:0] raw);
    int unsigned num;
    int unsigned billions;
    int unsigned millions;
    int unsigned thousands;
    num = int'(64'(raw) & MAX_VALUE);
    if (num == 0) begin
      pending_words.push_back(spoken_word_t'{i2ew_pkg::W_ZERO, 1'b1});
      return;
    end
    billions  = num / BILLION;
    millions  = (num / MILLION) % 1000;
    thousands = (num / THOUSAND) % 1000;
    if (billions != 0) begin
      spell_group(billions % 1000);
      add_word(i2ew_pkg::W_BILLION);
    end
    if (millions != 0) begin
      spell_group(millions);
      add_word(i2ew_pkg::W_MILLION);
    end
    if (thousands != 0) begin
      spell_group(thousands);
      add_word(i2ew_pkg::W_THOUSAND);
    end
    spell_group(num % 1000);
    pending_words[pending_words.size() - 1].last = 1'b1;
  endfunction

  // Draw a number: short readings, full-range, sparse-group and near-maximum ones
  function automatic logic [30:0] draw_number();
    longint unsigned total;
    case ($urandom_range(0, 4))
      0: return 31'($urandom_range(0, 999));
      1: return 31'($urandom_range(0, 999999));
      2: return 31'($urandom);
      3: begin
        total = longint'($urandom_range(0, 2)) * BILLION;
        if ($urandom_range(0, 1) != 0) total += longint'($urandom_range(0, 999)) * MILLION;
        if ($urandom_range(0, 1) != 0) total += longint'($urandom_range(0, 999)) * THOUSAND;
        if ($urandom_range(0, 1) != 0) total += $urandom_range(0, 999);
        if (total > MAX_VALUE) total -= BILLION;
        return 31'(total);
      end
      default: return 31'(MAX_VALUE) - 31'($urandom_range(0, 999));
    endcase
  endfunction

  // Drop valid for a short random burst, except in the quiet tail
  task automatic pause_sender();
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // Hold one input transaction until accepted, then queue its reading
  task automatic offer_number(input number_row_t row);
    in_valid_i <= 1'b1;
    value_i    <= row.value;
    do @(posedge clk_i); while (in_stall_o);
    if (row.has_word) pending_words.push_back(spoken_word_t'{row.word, 1'b1});
    else spell_number(row.value);
    numbers_read++;
  endtask

  task automatic wait_for_words();
    while (pending_words.size() != 0) @(posedge clk_i);
  endtask

  // Check each output transaction and drive random stall bursts
  always @(posedge clk_i) begin
    spoken_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_words.size() == 0) begin
        $error("word %0d last %0b arrived with nothing pending", word_o, last_o);
        error_count++;
      end else begin
        want = pending_words.pop_front();
        words_checked++;
        if (word_o !== want.word) begin
          $error("word: expected %0d, got %0d", want.word, word_o);
          error_count++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, last_o);
          error_count++;
        end
      end
    end
    if (!rst_ni || quiet_phase) begin
      stall_left = 0;
    end else if (stall_left == 0 && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 4);
    end
    out_stall_i <= (stall_left != 0);
    if (stall_left != 0) stall_left--;
  end

  // Main stimulus: reset, directed table, drain, random numbers, final drain
  initial begin
    number_row_t row;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (number_rows[i]) begin
      pause_sender();
      offer_number(number_rows[i]);
    end

    // hold off until the directed readings are fully out
    in_valid_i <= 1'b0;
    wait_for_words();

    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == NUM_RANDOM - QUIET_ITEMS) quiet_phase = 1'b1;
      pause_sender();
      row = '{draw_number(), 1'b0, i2ew_pkg::W_ZERO};
      offer_number(row);
    end

    in_valid_i <= 1'b0;
    wait_for_words();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Read out %0d numbers (%0d from the directed table), %0d words checked.",
             numbers_read, NUM_ROWS, words_checked);
    $display("Covered zero, teens, tens, hundreds, skipped groups and the 31-bit maximum.");
    if (error_count == 0) begin
      $display("tb_integer_to_english_words_top: clean");
    end else begin
      $display("tb_integer_to_english_words_top: errors");
    end
    $finish;
  end

  // Bound the run well past the slowest legal completion
  initial begin
    #5_000_000;
    $display("Timed out with %0d words still pending.", pending_words.size());
    $display("tb_integer_to_english_words_top: errors");
    $finish;
  end

endmodule

/* filelist.f */
rtl/i2ew_pkg.sv
rtl/integer_to_english_words_top.sv
tb/tb_integer_to_english_words_top.sv
